FILE: src/luhn_pkg.sv
package luhn_pkg;

  localparam int unsigned NumWidth = 63;
  localparam int unsigned NumDigits = 19;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned SumWidth = 4;

  localparam logic [1:0] ClassInvalid = 2'd0;
  localparam logic [1:0] ClassB = 2'd1;
  localparam logic [1:0] ClassC = 2'd2;
  localparam logic [1:0] ClassA = 2'd3;

  typedef struct packed {
    logic [NumWidth-1:0]   rest;
    logic [CountWidth-1:0] count;
    logic [SumWidth-1:0]   total;
    logic [3:0]            lead;
    logic [3:0]            lead2;
  } acc_t;

  function automatic logic [NumWidth-1:0] digit_step(int unsigned m, int unsigned k);
    logic [63:0] p;
    p = 64'(m);
    for (int unsigned i = 0; i < k; i++) p = p * 64'd10;
    return p[NumWidth-1:0];
  endfunction

endpackage

FILE: src/luhn_digit_stage.sv
module luhn_digit_stage #(
  parameter int unsigned Pos = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  luhn_pkg::acc_t    in_acc,
  output logic              out_valid,
  input  logic              out_ready,
  output luhn_pkg::acc_t    out_acc
);

  localparam int unsigned W = luhn_pkg::NumWidth;
  localparam logic Doubled = (Pos % 2) == 1;
  localparam logic [luhn_pkg::CountWidth-1:0] Here = luhn_pkg::CountWidth'(Pos + 1);
  localparam logic [luhn_pkg::CountWidth-1:0] Above = luhn_pkg::CountWidth'(Pos + 2);

  logic [W-1:0]   lim [9];
  logic [8:0]     ge;
  logic [W-1:0]   sub;
  logic [3:0]     dig;
  logic [4:0]     dd;
  logic [3:0]     contrib;
  logic [4:0]     sum;
  luhn_pkg::acc_t acc_next;

  // The digit at this decimal position is how many of its multiples fit in the rest.
  for (genvar m = 0; m < 9; m++) begin : g_cmp
    assign lim[m] = luhn_pkg::digit_step(m + 1, Pos);
    assign ge[m] = in_acc.rest >= lim[m];
  end

  always_comb begin
    dig = 4'd0;
    sub = '0;
    for (int j = 0; j < 9; j++) begin
      if (ge[j]) begin
        dig = 4'(j + 1);
        sub = lim[j];
      end
    end
    dd = {dig, 1'b0};
    if (Doubled) begin
      contrib = (dd > 5'd9) ? 4'(dd - 5'd9) : dd[3:0];
    end else begin
      contrib = dig;
    end
    sum = {1'b0, in_acc.total} + {1'b0, contrib};
    acc_next = in_acc;
    acc_next.rest = in_acc.rest - sub;
    acc_next.total = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
    if (in_acc.count == '0) begin
      if (dig != 4'd0) begin
        acc_next.count = Here;
        acc_next.lead = dig;
      end
    end else if (in_acc.count == Above) begin
      acc_next.lead2 = dig;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_acc <= acc_next;
    end
  end

endmodule

FILE: src/luhn_classify_stage.sv
module luhn_classify_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  luhn_pkg::acc_t  in_acc,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_data
);

  logic       ok;
  logic [1:0] cls;
  logic       lb;
  logic       lc;

  always_comb begin
    ok = in_acc.total == '0;
    lb = (in_acc.lead == 4'd3) && (in_acc.lead2 == 4'd4 || in_acc.lead2 == 4'd7);
    lc = (in_acc.lead == 4'd5) && (in_acc.lead2 >= 4'd1) && (in_acc.lead2 <= 4'd5);
    cls = luhn_pkg::ClassInvalid;
    if (ok) begin
      case (in_acc.count)
        5'd13: if (in_acc.lead == 4'd4) cls = luhn_pkg::ClassA;
        5'd15: if (lb) cls = luhn_pkg::ClassB;
        5'd16: begin
          if (in_acc.lead == 4'd4) cls = luhn_pkg::ClassA;
          else if (lc) cls = luhn_pkg::ClassC;
        end
        default: cls = luhn_pkg::ClassInvalid;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= {in_acc.count, ok, cls};
    end
  end

endmodule

FILE: src/card_number_luhn_classify_top.sv
// Luhn mod-10 check and brand classification of a card number given as a
// binary word. A pipeline of nineteen digit stages, each taking one decimal
// digit from the most significant position down by comparing the rest against
// the multiples of a fixed power of ten, feeds one classification stage, so a
// word is accepted every cycle while the output side is not stalled, and its
// result is registered in each digit stage in turn and then in the classification stage.
module card_number_luhn_classify_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [62:0] card_number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [1:0] card_class, [2] checksum_ok, [7:3] digit_count
);

  localparam int unsigned N = luhn_pkg::NumDigits;

  logic           v [N+1];
  logic           r [N+1];
  luhn_pkg::acc_t a [N+1];
  luhn_pkg::acc_t first;

  always_comb begin
    first = '0;
    first.rest = s_tdata[luhn_pkg::NumWidth-1:0];
  end
  assign a[0] = first;
  assign v[0] = s_tvalid;
  assign s_tready = r[0];

  for (genvar i = 0; i < N; i++) begin : g_dig
    luhn_digit_stage #(.Pos(N - 1 - i)) u_stage (
      .clk(clk), .rst(rst),
      .in_valid(v[i]), .in_ready(r[i]), .in_acc(a[i]),
      .out_valid(v[i+1]), .out_ready(r[i+1]), .out_acc(a[i+1])
    );
  end

  luhn_classify_stage u_cls (
    .clk(clk), .rst(rst),
    .in_valid(v[N]), .in_ready(r[N]), .in_acc(a[N]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule
